FILE: src/dxt3_pkg.sv
// ----------------------------------------------------------------------------
// dxt3_pkg - shared types and helpers for the DXT3 block decoder
// Palette entry and block types, endpoint widening and the divide by three.
// ----------------------------------------------------------------------------
`default_nettype none

package dxt3_pkg;

  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);
  localparam int PIXELS   = 16;
  localparam int PIX_W    = $clog2(PIXELS);
  localparam int OUT_W    = 40;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t [3:0]  pal;
    logic [31:0] idx;
    logic [63:0] alpha;
  } blk_t;

  function automatic rgb_t widen(input logic [15:0] word);
    rgb_t c;
    c.blue  = {word[4:0], 3'b000};
    c.green = {word[10:5], 2'b00};
    c.red   = {word[15:11], 3'b000};
    return c;
  endfunction

  // floor(x / 3) for x below 768: multiply by 683 / 2048
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] prod;
    prod = {11'd0, x} * 21'd683;
    return prod[18:11];
  endfunction

  // (2a + b + 1) / 3
  function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b);
    logic [9:0] sum;
    sum = {1'b0, a, 1'b0} + {2'b00, b} + 10'd1;
    return div3(sum);
  endfunction

endpackage

`default_nettype wire

FILE: src/dxt3_front.sv
// ----------------------------------------------------------------------------
// dxt3_front - block intake and palette build
// Widens both endpoints and forms the four-entry palette of one block.
// ----------------------------------------------------------------------------
`default_nettype none

module dxt3_front (
  input  wire logic [63:0] alpha_bits,
  input  wire logic [63:0] color_bits,
  output dxt3_pkg::blk_t   blk
);

  dxt3_pkg::rgb_t c0;
  dxt3_pkg::rgb_t c1;

  always_comb begin
    c0 = dxt3_pkg::widen(color_bits[15:0]);
    c1 = dxt3_pkg::widen(color_bits[31:16]);
    blk.pal[0] = c0;
    blk.pal[1] = c1;
    blk.pal[2].red   = dxt3_pkg::mix(c0.red, c1.red);
    blk.pal[2].green = dxt3_pkg::mix(c0.green, c1.green);
    blk.pal[2].blue  = dxt3_pkg::mix(c0.blue, c1.blue);
    blk.pal[3].red   = dxt3_pkg::mix(c1.red, c0.red);
    blk.pal[3].green = dxt3_pkg::mix(c1.green, c0.green);
    blk.pal[3].blue  = dxt3_pkg::mix(c1.blue, c0.blue);
    blk.idx   = color_bits[63:32];
    blk.alpha = alpha_bits;
  end

endmodule

`default_nettype wire

FILE: src/dxt3_queue.sv
// ----------------------------------------------------------------------------
// dxt3_queue - short block queue
// Holds decoded palettes between intake and pixel output.
// ----------------------------------------------------------------------------
`default_nettype none

module dxt3_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  dxt3_pkg::blk_t      wr_blk,
  output logic                full,
  input  wire logic           pop,
  output logic                nonempty,
  output dxt3_pkg::blk_t      rd_blk
);

  dxt3_pkg::blk_t                     mem [dxt3_pkg::QDEPTH];
  logic [dxt3_pkg::QPTR_W-1:0]        wr_ptr;
  logic [dxt3_pkg::QPTR_W-1:0]        rd_ptr;
  logic [dxt3_pkg::QCNT_W-1:0]        count;

  assign full     = (count == dxt3_pkg::QCNT_W'(dxt3_pkg::QDEPTH));
  assign nonempty = (count != '0);
  assign rd_blk   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_blk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == dxt3_pkg::QPTR_W'(dxt3_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == dxt3_pkg::QPTR_W'(dxt3_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/dxt3_back.sv
// ----------------------------------------------------------------------------
// dxt3_back - pixel emitter
// Walks the sixteen pixels of the head block into a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module dxt3_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       alpha_enable,
  input  wire logic                       q_valid,
  input  dxt3_pkg::blk_t                  q_blk,
  output logic                            q_pop,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [dxt3_pkg::OUT_W-1:0]      m_tdata,
  output logic                            m_tlast
);

  logic [dxt3_pkg::PIX_W-1:0] pix;
  logic                       load;
  logic [1:0]                 sel;
  logic [3:0]                 a4;
  dxt3_pkg::rgb_t             color;
  logic [7:0]                 alpha;
  logic                       is_last;

  always_comb begin
    load    = q_valid && (!m_tvalid || m_tready);
    sel     = q_blk.idx[{pix, 1'b0} +: 2];
    a4      = q_blk.alpha[{pix, 2'b00} +: 4];
    color   = q_blk.pal[sel];
    alpha   = alpha_enable ? {a4, 4'b0000} : 8'd0;
    is_last = (pix == dxt3_pkg::PIX_W'(dxt3_pkg::PIXELS - 1));
    q_pop   = load && is_last;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {4'b0000, pix[1:0], pix[3:2], alpha, color.red, color.green, color.blue};
      m_tlast <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        pix      <= pix + 1'b1;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/dxt3_block_decoder_core.sv
// ----------------------------------------------------------------------------
// dxt3_block_decoder_core - DXT3 (BC2) block decoder
// Decodes one 128-bit block into sixteen pixels, rows outer, columns inner.
// ----------------------------------------------------------------------------
//  channel   | direction | content
//  s_axis    | in        | one block per transfer (alpha word, color word)
//  m_axis    | out       | one pixel per transfer, tlast on the sixteenth
//  cfg       | in        | alpha_enable, always ready
//
//  A block leaves as sixteen pixels, one pixel per cycle while m_tready is high
//  and a block waits in the queue; the output register sets the pace. Palette
//  build is combinational: a block is written into the two-entry queue on its
//  transfer, and its pixels then pass through the output register.
//  Reset clears the queue, pixel counter and output valid; alpha_enable = 1.
//  A stalled output holds its pixel; intake keeps going until the queue fills.
`default_nettype none

module dxt3_block_decoder_core (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,   // alpha_bits[63:0], color_bits[127:64]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [39:0]       m_tdata,   // blue, green, red, alpha, pixel_row[33:32],
                                       // pixel_col[35:34], zero pad
  output logic              m_tlast,   // last_pixel
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_data   // alpha_enable
);

  logic           alpha_enable;
  dxt3_pkg::blk_t front_blk;
  dxt3_pkg::blk_t head_blk;
  logic           q_full;
  logic           q_nonempty;
  logic           q_pop;
  logic           push;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign push      = s_tvalid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_enable <= 1'b1;
    end else if (cfg_valid) begin
      alpha_enable <= cfg_data;
    end
  end

  dxt3_front u_front (
    .alpha_bits (s_tdata[63:0]),
    .color_bits (s_tdata[127:64]),
    .blk        (front_blk)
  );

  dxt3_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_blk   (front_blk),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .rd_blk   (head_blk)
  );

  dxt3_back u_back (
    .clk          (clk),
    .rst          (rst),
    .alpha_enable (alpha_enable),
    .q_valid      (q_nonempty),
    .q_blk        (head_blk),
    .q_pop        (q_pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast)
  );

endmodule

`default_nettype wire

FILE: src/dxt3_checker.sv
// ----------------------------------------------------------------------------
// dxt3_checker - port-level checks for the DXT3 block decoder
// Output hold, reset, pixel position and alpha nibble checks.
// ----------------------------------------------------------------------------
`default_nettype none

module dxt3_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [39:0]  m_tdata,
  input wire logic         m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[35:32] == 4'hF)))
    else $error("tlast does not match pixel position");

  a_alpha_nibble: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[27:24] == 4'h0 && m_tdata[39:36] == 4'h0)
    else $error("alpha low nibble or pad not zero");

endmodule

bind dxt3_block_decoder_core dxt3_checker u_dxt3_checker (.*);

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - DXT3 block decoder core testbench
// Sends DXT3 blocks over the input stream and checks every decoded pixel
// against a local palette decoder. It runs a directed table first, then
// random blocks in phases with alpha output on and off. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------

module tb;

  localparam int IDLE_LIMIT = 2000;
  localparam int END_WAIT   = 32;
  localparam int PHASES     = 6;
  localparam int PHASE_LEN  = 38;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic [1:0] row;
    logic [1:0] col;
    logic       last;
  } pixel_t;

  typedef struct packed {
    logic        aen;
    logic [63:0] abits;
    logic [63:0] cbits;
    logic        fixed;
    logic [31:0] px;     // alpha, red, green, blue from the top byte down
  } block_vec_t;

  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         s_tvalid  = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata   = '0;   // alpha_bits[63:0], color_bits[127:64]
  logic         m_tvalid;
  logic         m_tready  = 1'b0;
  logic [39:0]  m_tdata;          // blue, green, red, alpha, pixel_row, pixel_col
  logic         m_tlast;          // last_pixel
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic         cfg_data  = 1'b0; // alpha_enable

  pixel_t     pixel_q[$];
  block_vec_t dir_tab[$];
  logic       alpha_on;
  int         mismatches = 0;
  int         idle_cycles = 0;
  int         stall_left = 0;
  int         calm_left = 0;

  dxt3_block_decoder_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic pixel_t decode_pixel(logic [63:0] abits, logic [63:0] cbits,
                                          logic aen, int p);
    int     lo[3];
    int     hi[3];
    int     pal[3];
    int     sel;
    pixel_t px;
    lo[0] = int'(cbits[4:0]) << 3;
    lo[1] = int'(cbits[10:5]) << 2;
    lo[2] = int'(cbits[15:11]) << 3;
    hi[0] = int'(cbits[20:16]) << 3;
    hi[1] = int'(cbits[26:21]) << 2;
    hi[2] = int'(cbits[31:27]) << 3;
    sel = int'(cbits[32 + 2 * p +: 2]);
    for (int ch = 0; ch < 3; ch++) begin
      case (sel)
        0: pal[ch] = lo[ch];
        1: pal[ch] = hi[ch];
        2: pal[ch] = (2 * lo[ch] + hi[ch] + 1) / 3;
        default: pal[ch] = (lo[ch] + 2 * hi[ch] + 1) / 3;
      endcase
    end
    px.blue  = pal[0][7:0];
    px.green = pal[1][7:0];
    px.red   = pal[2][7:0];
    px.alpha = aen ? {abits[4 * p +: 4], 4'h0} : 8'h00;
    px.row   = p[3:2];
    px.col   = p[1:0];
    px.last  = (p == dxt3_pkg::PIXELS - 1);
    return px;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] pick_endpoint();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'hF800;
      3: return 16'h07E0;
      4: return 16'h001F;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_block(logic [63:0] abits, logic [63:0] cbits,
                            logic fixed, logic [31:0] px);
    pixel_t e;
    int     g;
    s_tvalid <= 1'b1;
    s_tdata  <= {cbits, abits};
    do @(posedge clk); while (!s_tready);
    for (int p = 0; p < dxt3_pkg::PIXELS; p++) begin
      e = decode_pixel(abits, cbits, alpha_on, p);
      if (fixed) begin
        {e.alpha, e.red, e.green, e.blue} = px;
      end
      pixel_q.push_back(e);
    end
    g = pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_alpha(logic aen);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= aen;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    alpha_on = aen;
  endtask

  // downstream ready: mostly ready, short and long stalls, calm stretches
  always @(posedge clk) begin
    int r;
    if (calm_left > 0) begin
      calm_left--;
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        calm_left = $urandom_range(50, 200);
        m_tready <= 1'b1;
      end else if (r < 70) begin
        m_tready <= 1'b1;
      end else if (r < 95) begin
        stall_left = $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        stall_left = $urandom_range(9, 39);
        m_tready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    pixel_t got;
    pixel_t e;
    if (!rst && m_tvalid && m_tready) begin
      got.blue  = m_tdata[7:0];
      got.green = m_tdata[15:8];
      got.red   = m_tdata[23:16];
      got.alpha = m_tdata[31:24];
      got.row   = m_tdata[33:32];
      got.col   = m_tdata[35:34];
      got.last  = m_tlast;
      if (pixel_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected pixel b=%h g=%h r=%h a=%h row=%0d col=%0d last=%b",
                 $time, got.blue, got.green, got.red, got.alpha, got.row, got.col,
                 got.last);
      end else begin
        e = pixel_q.pop_front();
        if (got !== e) begin
          mismatches++;
          $display("%0t: pixel mismatch expected b=%h g=%h r=%h a=%h row=%0d col=%0d last=%b",
                   $time, e.blue, e.green, e.red, e.alpha, e.row, e.col, e.last);
          $display("%0t:                actual   b=%h g=%h r=%h a=%h row=%0d col=%0d last=%b",
                   $time, got.blue, got.green, got.red, got.alpha, got.row, got.col,
                   got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] abits;
    logic [63:0] cbits;
    logic [15:0] c0;

    // aen, alpha word, color word, fixed result, fixed {a, r, g, b}
    dir_tab.push_back({1'b1, 64'h0, 64'h0, 1'b1, 32'h00000000});
    dir_tab.push_back({1'b1, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b1, 32'hF0F8FCF8});
    dir_tab.push_back({1'b1, 64'hFFFFFFFFFFFFFFFF, 64'h0, 1'b1, 32'hF0000000});
    dir_tab.push_back({1'b1, 64'h0, 64'h00000000_0000FFFF, 1'b1, 32'h00F8FCF8});
    dir_tab.push_back({1'b1, 64'h0, 64'h55555555_0000FFFF, 1'b1, 32'h00000000});
    dir_tab.push_back({1'b1, 64'h0123456789ABCDEF, 64'hAAAAAAAA_0000FFFF, 1'b0, 32'h0});
    dir_tab.push_back({1'b1, 64'hFEDCBA9876543210, 64'hFFFFFFFF_0000FFFF, 1'b0, 32'h0});
    dir_tab.push_back({1'b1, 64'h0, 64'hE4E4E4E4_FFFF0000, 1'b0, 32'h0});
    dir_tab.push_back({1'b1, 64'h3C5A96F00F69A5C3, 64'h1B1B1B1B_07E0F800, 1'b0, 32'h0});
    dir_tab.push_back({1'b1, 64'h8421842184218421, 64'hE4E4E4E4_001F07E0, 1'b0, 32'h0});
    dir_tab.push_back({1'b1, 64'h5A5A5A5AA5A5A5A5, 64'hD2B43C96_84217BEF, 1'b0, 32'h0});
    dir_tab.push_back({1'b1, 64'hFFFF0000FFFF0000, 64'h0F0F0F0F_F81F07E0, 1'b0, 32'h0});
    dir_tab.push_back({1'b0, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b1, 32'h00F8FCF8});
    dir_tab.push_back({1'b0, 64'hFFFFFFFFFFFFFFFF, 64'h0, 1'b1, 32'h00000000});
    dir_tab.push_back({1'b0, 64'h0123456789ABCDEF, 64'hE4E4E4E4_FFFF0000, 1'b0, 32'h0});
    dir_tab.push_back({1'b0, 64'h9E3779B97F4A7C15, 64'h6C078965_B5AD4A52, 1'b0, 32'h0});
    dir_tab.push_back({1'b1, 64'hF0F0F0F00F0F0F0F, 64'h1E1E1E1E_FFE00010, 1'b0, 32'h0});
    dir_tab.push_back({1'b1, 64'hFFFFFFFFFFFFFFFF, 64'h0, 1'b1, 32'hF0000000});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    alpha_on = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].aen != alpha_on) set_alpha(dir_tab[i].aen);
      send_block(dir_tab[i].abits, dir_tab[i].cbits, dir_tab[i].fixed, dir_tab[i].px);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      set_alpha(ph[0]);
      for (int n = 0; n < PHASE_LEN; n++) begin
        abits = {$urandom(), $urandom()};
        cbits = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
          6: cbits[31:0] = {pick_endpoint(), pick_endpoint()};
          7: begin
            c0 = pick_endpoint();
            cbits[31:0] = {c0, c0};
          end
          8: abits = $urandom_range(0, 1) ? 64'hFFFFFFFFFFFFFFFF : 64'h0;
          default: ;
        endcase
        send_block(abits, cbits, 1'b0, 32'h0);
      end
    end

    drain();
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: dxt3_block_decoder_core.f
src/dxt3_pkg.sv
src/dxt3_front.sv
src/dxt3_queue.sv
src/dxt3_back.sv
src/dxt3_block_decoder_core.sv
src/dxt3_checker.sv
tb/sv/tb.sv
